[rtl/oas_pkg.sv]
// Shared types, codes and register map for the obstacle avoidance sequencer.
// No dependencies; used by every module in rtl/.
`default_nettype none

package oas_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned InDataW = 80;
  localparam int unsigned OutDataW = 24;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_OBST_THRESH = 3'd0;
  localparam logic [2:0] REG_STOP_SETTLE = 3'd1;
  localparam logic [2:0] REG_TURN_MIN    = 3'd2;
  localparam logic [2:0] REG_RESUME_CRP  = 3'd3;
  localparam logic [2:0] REG_TURN_SPEED  = 3'd4;
  localparam logic [2:0] REG_RESUME_SPD  = 3'd5;

  localparam logic [15:0] RST_OBST_THRESH = 16'd400;
  localparam logic [15:0] RST_STOP_SETTLE = 16'd200;
  localparam logic [15:0] RST_TURN_MIN    = 16'd600;
  localparam logic [15:0] RST_RESUME_CRP  = 16'd400;
  localparam logic [7:0]  RST_TURN_SPEED  = 8'd180;
  localparam logic [7:0]  RST_RESUME_SPD  = 8'd150;

  // Drive commands
  localparam logic [1:0] CMD_STOP  = 2'd0;
  localparam logic [1:0] CMD_FWD   = 2'd1;
  localparam logic [1:0] CMD_LEFT  = 2'd2;
  localparam logic [1:0] CMD_RIGHT = 2'd3;

  // Phase codes as reported
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_STOP   = 3'd1;
  localparam logic [2:0] PH_EVAL   = 3'd2;
  localparam logic [2:0] PH_TURN   = 3'd3;
  localparam logic [2:0] PH_RESUME = 3'd4;

  // Status message codes
  localparam logic [2:0] ST_STOPPING = 3'd0;
  localparam logic [2:0] ST_CHOOSING = 3'd1;
  localparam logic [2:0] ST_TURNING  = 3'd2;
  localparam logic [2:0] ST_CLEAR_PATH = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_STOP   = 5'b00010,
    S_EVAL   = 5'b00100,
    S_TURN   = 5'b01000,
    S_RESUME = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [15:0] obstacle_threshold;
    logic [15:0] stop_settle_time;
    logic [15:0] turn_min_time;
    logic [15:0] resume_creep_time;
    logic [7:0]  turn_speed;
    logic [7:0]  creep_speed;
  } cfg_t;

  typedef struct packed {
    logic [15:0] right_range;
    logic [15:0] left_range;
    logic [15:0] front_range;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] status_code;
    logic       status_valid;
    logic [2:0] phase_now;
    logic [7:0] drive_speed;
    logic [1:0] drive_cmd;
    logic       drive_valid;
    logic       avoiding;
  } res_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] c;
    case (ph)
      S_IDLE:   c = PH_IDLE;
      S_STOP:   c = PH_STOP;
      S_EVAL:   c = PH_EVAL;
      S_TURN:   c = PH_TURN;
      S_RESUME: c = PH_RESUME;
      default:  c = PH_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/oas_cfg.sv]
// APB-style configuration register file for the sequencer.
// Depends on oas_pkg for the register map and reset values.
`default_nettype none

module oas_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [oas_pkg::AddrW-1:0] cfg_paddr,
  input  wire logic [31:0]              cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  output oas_pkg::cfg_t                 cfg_o
);

  oas_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        oas_pkg::REG_OBST_THRESH: cfg_nxt.obstacle_threshold = cfg_pwdata[15:0];
        oas_pkg::REG_STOP_SETTLE: cfg_nxt.stop_settle_time   = cfg_pwdata[15:0];
        oas_pkg::REG_TURN_MIN:    cfg_nxt.turn_min_time      = cfg_pwdata[15:0];
        oas_pkg::REG_RESUME_CRP:  cfg_nxt.resume_creep_time  = cfg_pwdata[15:0];
        oas_pkg::REG_TURN_SPEED:  cfg_nxt.turn_speed         = cfg_pwdata[7:0];
        oas_pkg::REG_RESUME_SPD:  cfg_nxt.creep_speed        = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      oas_pkg::REG_OBST_THRESH: cfg_prdata = {16'd0, cfg_r.obstacle_threshold};
      oas_pkg::REG_STOP_SETTLE: cfg_prdata = {16'd0, cfg_r.stop_settle_time};
      oas_pkg::REG_TURN_MIN:    cfg_prdata = {16'd0, cfg_r.turn_min_time};
      oas_pkg::REG_RESUME_CRP:  cfg_prdata = {16'd0, cfg_r.resume_creep_time};
      oas_pkg::REG_TURN_SPEED:  cfg_prdata = {24'd0, cfg_r.turn_speed};
      oas_pkg::REG_RESUME_SPD:  cfg_prdata = {24'd0, cfg_r.creep_speed};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.obstacle_threshold <= oas_pkg::RST_OBST_THRESH;
      cfg_r.stop_settle_time   <= oas_pkg::RST_STOP_SETTLE;
      cfg_r.turn_min_time      <= oas_pkg::RST_TURN_MIN;
      cfg_r.resume_creep_time  <= oas_pkg::RST_RESUME_CRP;
      cfg_r.turn_speed         <= oas_pkg::RST_TURN_SPEED;
      cfg_r.creep_speed        <= oas_pkg::RST_RESUME_SPD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/oas_core.sv]
// Phase sequencer: state registers and the per-item decision logic.
// Depends on oas_pkg for types and codes.
`default_nettype none

module oas_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   step,
  input  wire oas_pkg::item_t item,
  input  wire oas_pkg::cfg_t  cfg,
  output oas_pkg::res_t  res
);

  oas_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]     start_r, start_nxt;
  logic            left_r, left_nxt;
  logic [31:0]     elapsed;
  logic            obstacle;
  logic [1:0]      turn_cmd;

  // wrapping difference; compares below are unsigned
  assign elapsed  = item.time_ms - start_r;
  assign obstacle = item.front_range < cfg.obstacle_threshold;
  assign turn_cmd = left_r ? oas_pkg::CMD_LEFT : oas_pkg::CMD_RIGHT;

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    left_nxt  = left_r;
    res       = '0;
    case (phase_r)
      oas_pkg::S_IDLE: begin
        if (obstacle) begin
          res.avoiding     = 1'b1;
          res.drive_valid  = 1'b1;
          phase_nxt        = oas_pkg::S_STOP;
          start_nxt        = item.time_ms;
          res.status_valid = 1'b1;
          res.status_code  = oas_pkg::ST_STOPPING;
        end
      end
      oas_pkg::S_STOP: begin
        res.avoiding    = 1'b1;
        res.drive_valid = 1'b1;
        if (elapsed >= {16'd0, cfg.stop_settle_time}) begin
          phase_nxt        = oas_pkg::S_EVAL;
          start_nxt        = item.time_ms;
          res.status_valid = 1'b1;
          res.status_code  = oas_pkg::ST_CHOOSING;
        end
      end
      oas_pkg::S_EVAL: begin
        left_nxt         = item.left_range >= item.right_range;
        res.avoiding     = 1'b1;
        res.drive_valid  = 1'b1;
        res.drive_cmd    = left_nxt ? oas_pkg::CMD_LEFT : oas_pkg::CMD_RIGHT;
        res.drive_speed  = cfg.turn_speed;
        phase_nxt        = oas_pkg::S_TURN;
        start_nxt        = item.time_ms;
        res.status_valid = 1'b1;
        res.status_code  = oas_pkg::ST_TURNING;
      end
      oas_pkg::S_TURN: begin
        res.avoiding    = 1'b1;
        res.drive_valid = 1'b1;
        res.drive_cmd   = turn_cmd;
        res.drive_speed = cfg.turn_speed;
        if (!obstacle && elapsed >= {16'd0, cfg.turn_min_time}) begin
          phase_nxt        = oas_pkg::S_RESUME;
          start_nxt        = item.time_ms;
          res.status_valid = 1'b1;
          res.status_code  = oas_pkg::ST_CLEAR_PATH;
        end else if (elapsed >= {15'd0, cfg.turn_min_time, 1'b0}) begin
          // timeout at twice the minimum, kept at 17 bits
          phase_nxt        = oas_pkg::S_RESUME;
          start_nxt        = item.time_ms;
          res.status_valid = 1'b1;
          res.status_code  = oas_pkg::ST_TIMEOUT;
        end
      end
      oas_pkg::S_RESUME: begin
        res.avoiding    = 1'b1;
        res.drive_valid = 1'b1;
        res.drive_cmd   = oas_pkg::CMD_FWD;
        res.drive_speed = cfg.creep_speed;
        if (elapsed >= {16'd0, cfg.resume_creep_time}) begin
          // forward command still goes out on the leaving item
          res.avoiding     = 1'b0;
          phase_nxt        = oas_pkg::S_IDLE;
          start_nxt        = item.time_ms;
          res.status_valid = 1'b1;
          res.status_code  = oas_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
    res.phase_now = oas_pkg::phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= oas_pkg::S_IDLE;
      start_r <= 32'd0;
      left_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/obstacle_avoidance_sequencer.sv]
// Obstacle avoidance sequencer top level: input and result registers around
// the phase sequencer. Depends on oas_pkg, oas_cfg and oas_core.
`default_nettype none

// One update item in, one result item out, one item per cycle sustained
// while out_tready is held high. An item is captured in an input register,
// judged in the following cycle against the current phase (a 32-bit elapsed
// subtraction and a few compares) and lands in the result register. Both
// the input and the result register stay full under back-pressure; the
// input side keeps accepting whenever the result register can move.
// Configuration registers sit at byte addresses 0x00..0x14 and should only
// be written while idle.
module obstacle_avoidance_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // tdata: time_ms[31:0], front_range[47:32], left_range[63:48],
  //        right_range[79:64]
  input  wire logic [oas_pkg::InDataW-1:0] in_tdata,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // tdata: avoiding[0], drive_valid[1], drive_cmd[3:2], drive_speed[11:4],
  //        phase_now[14:12], status_valid[15], status_code[18:16], zero[23:19]
  output logic [oas_pkg::OutDataW-1:0]     out_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [oas_pkg::AddrW-1:0]   cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  oas_pkg::cfg_t  cfg;
  oas_pkg::item_t item_r;
  oas_pkg::res_t  res, res_r;
  logic           in_valid_r;
  logic           out_valid_r;
  logic           step;

  // item in the input register moves on when the result register is free
  assign step      = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | step;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r};

  oas_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg_o      (cfg)
  );

  oas_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (item_r),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= oas_pkg::item_t'(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

[tb/obstacle_avoidance_sequencer_tb.sv]
// Self-checking bench for obstacle_avoidance_sequencer: update items in, one result item out.
// It predicts every result with its own model of the phase sequencer.
// Depends on oas_pkg and the RTL under rtl/.
module obstacle_avoidance_sequencer_tb;
  import oas_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int IdleLimit = 2000;
  localparam int ChunkUpdates = 270;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_SHORT_CYCLE,
    READY_LONG_STALL
  } ready_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tvalid = 1'b0;
  wire                 in_tready;
  wire [OutDataW-1:0]  out_tdata;
  wire                 out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [AddrW-1:0]    cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  wire [31:0]          cfg_prdata;
  wire                 cfg_pready;

  obstacle_avoidance_sequencer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #HalfPeriod clk = ~clk;

  // Sequencer model state and its copy of the registers
  cfg_t        regs_model;
  logic [2:0]  seq_phase;
  logic [31:0] seq_start;
  logic        seq_left;
  logic [31:0] clock_ms;

  res_t        predicted_results[$];
  int          fail_count = 0;
  int          results_checked = 0;
  int          updates_sent = 0;
  int          burst_left = 0;
  int unsigned phase_entries[6];

  function automatic res_t advance_sequencer(input item_t u);
    res_t        r;
    logic [31:0] elapsed;
    logic [2:0]  nxt;
    logic [2:0]  code;
    logic        moved;
    r = '0;
    elapsed = u.time_ms - seq_start;
    nxt = seq_phase;
    code = ST_STOPPING;
    moved = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (u.front_range < regs_model.obstacle_threshold) begin
          r.avoiding = 1'b1;
          r.drive_valid = 1'b1;
          r.drive_cmd = CMD_STOP;
          nxt = PH_STOP;
          code = ST_STOPPING;
          moved = 1'b1;
        end
      end
      PH_STOP: begin
        r.avoiding = 1'b1;
        r.drive_valid = 1'b1;
        r.drive_cmd = CMD_STOP;
        if (elapsed >= {16'd0, regs_model.stop_settle_time}) begin
          nxt = PH_EVAL;
          code = ST_CHOOSING;
          moved = 1'b1;
        end
      end
      PH_EVAL: begin
        seq_left = (u.left_range >= u.right_range);
        r.avoiding = 1'b1;
        r.drive_valid = 1'b1;
        r.drive_cmd = seq_left ? CMD_LEFT : CMD_RIGHT;
        r.drive_speed = regs_model.turn_speed;
        nxt = PH_TURN;
        code = ST_TURNING;
        moved = 1'b1;
      end
      PH_TURN: begin
        r.avoiding = 1'b1;
        r.drive_valid = 1'b1;
        r.drive_cmd = seq_left ? CMD_LEFT : CMD_RIGHT;
        r.drive_speed = regs_model.turn_speed;
        if (u.front_range >= regs_model.obstacle_threshold &&
            elapsed >= {16'd0, regs_model.turn_min_time}) begin
          nxt = PH_RESUME;
          code = ST_CLEAR_PATH;
          moved = 1'b1;
        end else if (elapsed >= {15'd0, regs_model.turn_min_time, 1'b0}) begin
          // timeout is twice the minimum, kept at 17 bits
          nxt = PH_RESUME;
          code = ST_TIMEOUT;
          moved = 1'b1;
        end
      end
      PH_RESUME: begin
        r.avoiding = 1'b1;
        r.drive_valid = 1'b1;
        r.drive_cmd = CMD_FWD;
        r.drive_speed = regs_model.creep_speed;
        if (elapsed >= {16'd0, regs_model.resume_creep_time}) begin
          // last creep item still drives forward but hands the motors back
          r.avoiding = 1'b0;
          nxt = PH_IDLE;
          code = ST_DONE;
          moved = 1'b1;
        end
      end
      default: ;
    endcase
    if (moved) begin
      seq_phase = nxt;
      seq_start = u.time_ms;
      r.status_valid = 1'b1;
      r.status_code = code;
      phase_entries[code]++;
    end
    r.phase_now = seq_phase;
    return r;
  endfunction

  function automatic item_t make_update(input logic [31:0] t, input logic [15:0] front,
                                        input logic [15:0] left, input logic [15:0] right);
    item_t u;
    u.time_ms = t;
    u.front_range = front;
    u.left_range = left;
    u.right_range = right;
    return u;
  endfunction

  // Random update shaped by the predicted phase so that timing boundaries get hit
  function automatic item_t next_update();
    item_t       u;
    logic [31:0] span;
    int unsigned pick;
    case (seq_phase)
      PH_STOP:   span = 32'(regs_model.stop_settle_time);
      PH_TURN:   span = ($urandom_range(0, 1) == 0) ? 32'(regs_model.turn_min_time)
                                                     : {15'd0, regs_model.turn_min_time, 1'b0};
      PH_RESUME: span = 32'(regs_model.resume_creep_time);
      default:   span = 32'd100;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      clock_ms = $urandom;
    end else if (pick < 18) begin
      clock_ms = seq_start + span;
    end else if (pick < 24) begin
      clock_ms = seq_start + span - 32'd1;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, span / 3 + 2);
    end
    u.time_ms = clock_ms;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      u.front_range = 16'h0000;
    end else if (pick < 10) begin
      u.front_range = 16'hFFFF;
    end else if (pick < 50 && regs_model.obstacle_threshold != 16'd0) begin
      u.front_range = 16'($urandom_range(0, regs_model.obstacle_threshold - 1));
    end else begin
      u.front_range = 16'($urandom_range(regs_model.obstacle_threshold, 16'hFFFF));
    end
    u.left_range = 16'($urandom);
    u.right_range = ($urandom_range(0, 4) == 0) ? u.left_range : 16'($urandom);
    return u;
  endfunction

  function automatic logic [15:0] random_span();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000));
  endfunction

  // Sender: bursts of random length, random gaps between them
  task automatic send_update(input item_t u);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata <= u;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted_results.push_back(advance_sequencer(u));
    updates_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_OBST_THRESH: regs_model.obstacle_threshold = value[15:0];
      REG_STOP_SETTLE: regs_model.stop_settle_time = value[15:0];
      REG_TURN_MIN:    regs_model.turn_min_time = value[15:0];
      REG_RESUME_CRP:  regs_model.resume_creep_time = value[15:0];
      REG_TURN_SPEED:  regs_model.turn_speed = value[7:0];
      REG_RESUME_SPD:  regs_model.creep_speed = value[7:0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] thresh, input logic [15:0] settle,
                                input logic [15:0] turn_min, input logic [15:0] creep,
                                input logic [7:0] turn_spd, input logic [7:0] resume_spd);
    wait_for_results();
    write_reg(REG_OBST_THRESH, 32'(thresh));
    write_reg(REG_STOP_SETTLE, 32'(settle));
    write_reg(REG_TURN_MIN, 32'(turn_min));
    write_reg(REG_RESUME_CRP, 32'(creep));
    write_reg(REG_TURN_SPEED, 32'(turn_spd));
    write_reg(REG_RESUME_SPD, 32'(resume_spd));
  endtask

  // Full avoidance runs at reset settings: boundaries, wrap of the ms counter,
  // both turn exits and all three side-range orderings.
  task automatic test_directed_walkthrough();
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] t2;
    t0 = 32'hFFFF_FF00;
    t1 = t0 + 32'd201;
    t2 = t1 + 32'd600;
    send_update(make_update(32'd0, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_update(make_update(32'hFFFF_FFFF, RST_OBST_THRESH, 16'hFFFF, 16'h0000));
    send_update(make_update(t0, RST_OBST_THRESH - 16'd1, 16'd10, 16'd20));
    send_update(make_update(t0 + 32'd199, 16'd0, 16'd0, 16'd0));
    send_update(make_update(t0 + 32'd200, 16'd0, 16'd0, 16'd0));
    send_update(make_update(t1, 16'd0, 16'd1234, 16'd1234));
    send_update(make_update(t1 + 32'd599, 16'hFFFF, 16'd0, 16'd0));
    send_update(make_update(t1 + 32'd600, 16'd0, 16'd0, 16'd0));
    send_update(make_update(t2, RST_OBST_THRESH, 16'd0, 16'd0));
    send_update(make_update(t2 + 32'd399, 16'd0, 16'd0, 16'd0));
    send_update(make_update(t2 + 32'd400, 16'hFFFF, 16'd0, 16'd0));
    // obstacle held through the turn: ends on the timeout
    send_update(make_update(32'd5000, 16'd0, 16'd0, 16'd0));
    send_update(make_update(32'd5200, 16'd0, 16'd0, 16'd0));
    send_update(make_update(32'd5200, 16'd0, 16'h0000, 16'hFFFF));
    send_update(make_update(32'd6399, 16'd0, 16'd0, 16'd0));
    send_update(make_update(32'd6400, 16'd0, 16'd0, 16'd0));
    send_update(make_update(32'd6800, 16'd0, 16'd0, 16'd0));
    send_update(make_update(32'd6800, 16'd0, 16'd0, 16'd0));
    send_update(make_update(32'd7000, 16'd0, 16'd0, 16'd0));
    send_update(make_update(32'd7000, 16'd0, 16'hFFFF, 16'h0000));
    send_update(make_update(32'd7600, 16'hFFFF, 16'd0, 16'd0));
    send_update(make_update(32'd8000, 16'd0, 16'd0, 16'd0));
  endtask

  task automatic test_register_extremes();
    apply_settings(16'hFFFF, 16'd0, 16'd0, 16'd0, 8'd0, 8'hFF);
    repeat (40) send_update(next_update());
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'd0);
    repeat (40) send_update(next_update());
    apply_settings(16'd0, random_span(), random_span(), random_span(),
                   8'($urandom), 8'($urandom));
    repeat (40) send_update(next_update());
    // doubled minimum crosses into bit 16
    apply_settings(16'd1, 16'd1, 16'h8000, 16'd1, 8'($urandom), 8'($urandom));
    repeat (40) send_update(next_update());
    apply_settings(16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 8'h80, 8'h7F);
    repeat (40) send_update(next_update());
  endtask

  task automatic test_random_updates();
    for (int chunk = 0; chunk < 6; chunk++) begin
      apply_settings(16'($urandom_range(1, 16'hFFFF)), random_span(), random_span(),
                     random_span(), 8'($urandom), 8'($urandom));
      repeat (ChunkUpdates) send_update(next_update());
    end
  endtask

  // Receiver: stalls on a pattern that is picked anew at random intervals
  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned mode_left = 0;
  int unsigned ready_tick = 0;

  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS:      out_tready <= 1'b1;
      READY_RANDOM:      out_tready <= ($urandom_range(0, 3) != 0);
      READY_SHORT_CYCLE: out_tready <= (ready_tick % 5) < 2;
      default:           out_tready <= (ready_tick % 24) < 4;
    endcase
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(res_t)-1:0];
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result item: expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        results_checked++;
        check_field("avoiding", 8'(want.avoiding), 8'(got.avoiding));
        check_field("drive_valid", 8'(want.drive_valid), 8'(got.drive_valid));
        check_field("drive_cmd", 8'(want.drive_cmd), 8'(got.drive_cmd));
        check_field("drive_speed", want.drive_speed, got.drive_speed);
        check_field("phase_now", 8'(want.phase_now), 8'(got.phase_now));
        check_field("status_valid", 8'(want.status_valid), 8'(got.status_valid));
        check_field("status_code", 8'(want.status_code), 8'(got.status_code));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("** obstacle_avoidance_sequencer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run
    regs_model = '{obstacle_threshold: RST_OBST_THRESH, stop_settle_time: RST_STOP_SETTLE,
                   turn_min_time: RST_TURN_MIN, resume_creep_time: RST_RESUME_CRP,
                   turn_speed: RST_TURN_SPEED, creep_speed: RST_RESUME_SPD};
    seq_phase = PH_IDLE;
    seq_start = 32'd0;
    seq_left = 1'b0;
    clock_ms = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_walkthrough();
    test_register_extremes();
    test_random_updates();
    wait_for_results();
    $display("Sent %0d update items, checked %0d result items, %0d mismatches.",
             updates_sent, results_checked, fail_count);
    $display("Entries: stop %0d, choose %0d, turn %0d, clear %0d, timeout %0d, done %0d.",
             phase_entries[ST_STOPPING], phase_entries[ST_CHOOSING],
             phase_entries[ST_TURNING], phase_entries[ST_CLEAR_PATH],
             phase_entries[ST_TIMEOUT], phase_entries[ST_DONE]);
    if (fail_count == 0) begin
      $display("** obstacle_avoidance_sequencer: PASSED **");
    end else begin
      $display("** obstacle_avoidance_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
